// File: hw/rtl/ppld_pkg.sv
// Package for the planar point/line distance unit.
// Holds widths, constants and the transaction and cell structs; no dependencies.
`default_nettype none
package ppld_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_EXTRA = 8;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DEN_W      = 2 * COORD_BITS + 2;
  localparam int NUM_W      = 2 * DEN_W + 2 * FRAC_EXTRA;
  localparam int ROOT_W     = COORD_BITS + FRAC_EXTRA + 2;
  localparam int Y_W        = ROOT_W + DEN_W;
  localparam int TRIAL_W    = DEN_W + 2 * ROOT_W + 2;
  localparam int IDX_W      = $clog2(ROOT_W);
  localparam int DIST_W     = COORD_BITS + FRAC_EXTRA + 1;
  localparam int LATENCY    = ROOT_W + 4;

  // (isqrt(2^(2*COORD_BITS+1)) + 1) << FRAC_EXTRA
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(23726592);

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_LINE  = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } ppld_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_res;
    logic              degenerate;
  } ppld_out_t;

  // data handed from one root cell to the next
  typedef struct packed {
    logic              vld;
    logic              degen;
    logic [NUM_W-1:0]  rem;
    logic [Y_W-1:0]    y;
    logic [DEN_W-1:0]  den;
    logic [ROOT_W-1:0] root;
  } ppld_cell_t;

endpackage
`default_nettype wire

// File: hw/rtl/ppld_front.sv
// Front end: differences, products, determinant and squared lengths (4 stages).
// Depends on ppld_pkg.
`default_nettype none
module ppld_front
  import ppld_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       vld_i,
  input  wire ppld_in_t   in_i,
  output ppld_cell_t      cell_o
);

  logic                     v1_q, v2_q, v3_q;
  logic                     c1_q, c2_q, c3_q;
  logic signed [DIFF_W-1:0] u1_q, w1_q, u2_q, w2_q, e1_q, e2_q;
  logic signed [PROD_W-1:0] p1_q, p2_q, s1_q, s2_q;
  logic [DEN_W-1:0]         det_q, sum_q;
  logic signed [PROD_W:0]   det_s;
  ppld_cell_t               cell_d, cell_q;

  function automatic logic signed [DIFF_W-1:0] sub(input logic signed [COORD_BITS-1:0] a,
                                                   input logic signed [COORD_BITS-1:0] b);
    sub = DIFF_W'(a) - DIFF_W'(b);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= in_i.cmd;
    u1_q <= sub(in_i.ax, in_i.bx);
    w1_q <= sub(in_i.py, in_i.by);
    u2_q <= sub(in_i.ay, in_i.by);
    w2_q <= sub(in_i.px, in_i.bx);
    e1_q <= (in_i.cmd == CMD_LINE) ? sub(in_i.ax, in_i.bx) : sub(in_i.px, in_i.ax);
    e2_q <= (in_i.cmd == CMD_LINE) ? sub(in_i.ay, in_i.by) : sub(in_i.py, in_i.ay);
    c2_q <= c1_q;
    p1_q <= u1_q * w1_q;
    p2_q <= u2_q * w2_q;
    s1_q <= e1_q * e1_q;
    s2_q <= e2_q * e2_q;
    c3_q <= c2_q;
    det_q <= det_s[PROD_W] ? DEN_W'(-det_s) : DEN_W'(det_s);
    sum_q <= DEN_W'(s1_q) + DEN_W'(s2_q);
  end

  assign det_s = (PROD_W + 1)'(p1_q) - (PROD_W + 1)'(p2_q);

  always_comb begin
    cell_d       = '0;
    cell_d.vld   = v3_q;
    cell_d.degen = (c3_q == CMD_LINE) && (sum_q == '0);
    if (c3_q == CMD_LINE) begin
      cell_d.rem = (NUM_W'(det_q) * NUM_W'(det_q)) << (2 * FRAC_EXTRA);
      cell_d.den = sum_q;
    end else begin
      cell_d.rem = NUM_W'(sum_q) << (2 * FRAC_EXTRA);
      cell_d.den = DEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: hw/rtl/ppld_cell.sv
// One root cell: decides one result bit of r with r*r*den <= num.
// Depends on ppld_pkg.
`default_nettype none
module ppld_cell
  import ppld_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] bit_idx_i,
  input  wire ppld_cell_t       cell_i,
  output ppld_cell_t            cell_o
);

  // y tracks root*den; trial = (2*root*2^b + 4^b) * den
  logic [TRIAL_W-1:0] trial;
  logic               fits;
  ppld_cell_t         cell_d, cell_q;

  assign trial = (TRIAL_W'(cell_i.y) << (bit_idx_i + 1'b1))
               + (TRIAL_W'(cell_i.den) << {bit_idx_i, 1'b0});
  assign fits  = trial <= TRIAL_W'(cell_i.rem);

  always_comb begin
    cell_d = cell_i;
    if (fits) begin
      cell_d.rem  = cell_i.rem - trial[NUM_W-1:0];
      cell_d.y    = cell_i.y + (Y_W'(cell_i.den) << bit_idx_i);
      cell_d.root = cell_i.root | (ROOT_W'(1) << bit_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: hw/rtl/planar_point_line_distance_top.sv
// Top level of the planar point/line distance unit.
// Depends on ppld_pkg, ppld_front and ppld_cell.
`default_nettype none
// Usage:
//   A transaction is accepted at a rising edge with start_i high and busy_o
//   low. busy_o is always low: a new transaction may enter every cycle.
//   in_i carries cmd and the points P, A, B (signed coordinates).
//   cmd 0 gives |P - A|; cmd 1 gives the distance from P to line AB.
//   The result appears on res_o for exactly one cycle with done_o high,
//   in acceptance order.
//   Datapath: 4 front stages (differences, 17x17 products, determinant and
//   squared length, square of determinant), then a chain of 26 identical
//   root cells, one result bit per cell, most significant first. Each cell
//   keeps the remainder num - r*r*den and r*den, so it needs only shifts,
//   adds, one wide subtract and one compare.
//   cmd 1 with A equal to B flags degenerate and gives the maximum distance.
//   The receiver cannot stall; results must be taken when done_o is high.
//   Reset clears all valid flags; transactions in flight are dropped.
module planar_point_line_distance_top
  import ppld_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire ppld_in_t in_i,
  output logic          busy_o,
  output logic          done_o,
  output ppld_out_t     res_o
);

  ppld_cell_t chain [ROOT_W+1];

  assign busy_o = 1'b0;

  ppld_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i && !busy_o),
    .in_i   (in_i),
    .cell_o (chain[0])
  );

  // cell k settles bit ROOT_W-1-k
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    ppld_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bit_idx_i (IDX_W'(ROOT_W - 1 - k)),
      .cell_i    (chain[k]),
      .cell_o    (chain[k+1])
    );
  end

  always_comb begin
    done_o               = chain[ROOT_W].vld;
    res_o.degenerate     = chain[ROOT_W].degen;
    if (chain[ROOT_W].degen || (chain[ROOT_W].root > ROOT_W'(DIST_MAX))) begin
      res_o.dist_res = DIST_MAX;
    end else begin
      res_o.dist_res = chain[ROOT_W].root[DIST_W-1:0];
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(LATENCY) done_o) else $error("result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##(LATENCY) !done_o) else $error("spurious result");

  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.degenerate) |-> (res_o.dist_res == DIST_MAX))
    else $error("degenerate not saturated");

endmodule
`default_nettype wire
